// File: hw/rtl/lrds_pkg.sv
// Shared types and codes for the link reconnect/disconnect sequencer.
// Used by lrds_csr, lrds_step, the top level and lrds_checker.
package lrds_pkg;

   // link modes
   localparam logic [1:0] MODE_WLAN = 2'd0;
   localparam logic [1:0] MODE_CELL = 2'd1;
   localparam logic [1:0] MODE_DUAL = 2'd2;
   localparam logic [1:0] MODE_BAD  = 2'd3;

   // input function codes
   localparam logic [2:0] FN_RECONNECT  = 3'd0;
   localparam logic [2:0] FN_DISCONNECT = 3'd1;
   localparam logic [2:0] FN_EFFECT_OK  = 3'd2;
   localparam logic [2:0] FN_EFFECT_BAD = 3'd3;
   localparam logic [2:0] FN_READY      = 3'd4;
   localparam logic [2:0] FN_TERMINAL   = 3'd5;

   // result codes
   localparam logic [1:0] RC_OK          = 2'd0;
   localparam logic [1:0] RC_BAD_MODE    = 2'd1;
   localparam logic [1:0] RC_BAD_STATE   = 2'd2;
   localparam logic [1:0] RC_UNSUPPORTED = 2'd3;

   // external effects
   localparam logic [2:0] EF_NONE         = 3'd0;
   localparam logic [2:0] EF_APPLY_CFG    = 3'd1;
   localparam logic [2:0] EF_CONNECT_WLAN = 3'd2;
   localparam logic [2:0] EF_CELL_OFF     = 3'd3;
   localparam logic [2:0] EF_CELL_ON      = 3'd4;
   localparam logic [2:0] EF_DISC_WLAN    = 3'd5;
   localparam logic [2:0] EF_REPORT_DOWN  = 3'd6;

   // operation status
   localparam logic [2:0] ST_ACCEPTED  = 3'd0;
   localparam logic [2:0] ST_BUSY      = 3'd1;
   localparam logic [2:0] ST_FAILED    = 3'd2;
   localparam logic [2:0] ST_COMPLETED = 3'd3;
   localparam logic [2:0] ST_NO_ACTION = 3'd4;

   // register indexes
   localparam logic [1:0] REG_LINK_MODE = 2'd0;
   localparam logic [1:0] REG_STARTED   = 2'd1;
   localparam logic [1:0] REG_WLAN_CFG  = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_NONE       = 2'd0,
      OP_RECONNECT  = 2'd1,
      OP_DISCONNECT = 2'd2
   } op_type;

   typedef struct packed {
      logic [2:0] func;
      logic       ready_flag;
      logic [1:0] ready_iface;
   } req_item_type;

   typedef struct packed {
      logic [1:0] result_code;
      logic [2:0] next_effect;
      logic       status_valid;
      logic [2:0] op_status;
      logic       snap_changed;
      logic       snap_ready;
      logic [1:0] snap_iface;
      logic       snap_offline;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] link_mode;
      logic       manager_started;
      logic       wlan_config_present;
   } cfg_type;

   typedef struct packed {
      logic       offline_flag;
      logic       ready_state;
      logic [1:0] active_iface;
      logic       reconnecting;
      logic       disconnecting;
      op_type     current_op;
      logic [2:0] op_step;
      logic       op_failed;
      logic       wlan_path_down;
      logic       cell_path_down;
      logic [2:0] awaited_effect;
   } seq_state_type;

endpackage

// File: hw/rtl/lrds_csr.sv
// Configuration registers behind the APB-style port.
// Depends on lrds_pkg for the register indexes and cfg_type.
module lrds_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lrds_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lrds_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lrds_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output lrds_pkg::cfg_type                   cfg
);

   lrds_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]        reg_index;
   logic              wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            lrds_pkg::REG_LINK_MODE: cfg_in.link_mode           = pwdata[1:0];
            lrds_pkg::REG_STARTED:   cfg_in.manager_started     = pwdata[0];
            lrds_pkg::REG_WLAN_CFG:  cfg_in.wlan_config_present = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         lrds_pkg::REG_LINK_MODE: prdata[1:0] = cfg_ff.link_mode;
         lrds_pkg::REG_STARTED:   prdata[0]   = cfg_ff.manager_started;
         lrds_pkg::REG_WLAN_CFG:  prdata[0]   = cfg_ff.wlan_config_present;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/lrds_step.sv
// Decision logic for one item: next sequencer state and the result item.
// Depends on lrds_pkg for codes and struct types.
module lrds_step (
   input  lrds_pkg::cfg_type       cfg,
   input  lrds_pkg::seq_state_type cur,
   input  lrds_pkg::req_item_type  req,
   output lrds_pkg::seq_state_type nxt,
   output lrds_pkg::rsp_item_type  rsp
);

   logic       fail;
   logic [2:0] step_inc;
   logic [2:0] done;
   logic [1:0] rc;
   logic [2:0] eff;
   logic       sv;
   logic [2:0] st;
   logic       chg;
   logic       no_path;
   logic       is_wlan;
   logic       is_cell;
   logic       is_dual;

   assign fail     = (req.func == lrds_pkg::FN_EFFECT_BAD);
   assign step_inc = cur.op_step + 3'd1;
   assign done     = cur.awaited_effect;
   assign is_wlan  = (cfg.link_mode == lrds_pkg::MODE_WLAN);
   assign is_cell  = (cfg.link_mode == lrds_pkg::MODE_CELL);
   assign is_dual  = (cfg.link_mode == lrds_pkg::MODE_DUAL);

   always_comb begin
      nxt     = cur;
      rc      = lrds_pkg::RC_OK;
      eff     = lrds_pkg::EF_NONE;
      sv      = 1'b0;
      st      = lrds_pkg::ST_ACCEPTED;
      chg     = 1'b0;
      no_path = 1'b0;

      if (cfg.link_mode == lrds_pkg::MODE_BAD) begin
         rc = lrds_pkg::RC_BAD_MODE;
      end else if (!cfg.manager_started ||
                   (req.func == lrds_pkg::FN_RECONNECT && cur.disconnecting) ||
                   (req.func == lrds_pkg::FN_DISCONNECT && cur.reconnecting)) begin
         rc = lrds_pkg::RC_BAD_STATE;
      end else begin
         case (req.func) inside
            lrds_pkg::FN_RECONNECT: begin
               if (cur.reconnecting) begin
                  sv = 1'b1;
                  st = lrds_pkg::ST_BUSY;
               end else begin
                  nxt.offline_flag   = 1'b0;
                  nxt.ready_state    = 1'b0;
                  nxt.active_iface   = 2'd0;
                  nxt.reconnecting   = 1'b1;
                  nxt.disconnecting  = 1'b0;
                  nxt.current_op     = lrds_pkg::OP_RECONNECT;
                  nxt.op_step        = 3'd0;
                  nxt.op_failed      = 1'b0;
                  nxt.wlan_path_down = is_dual && !cfg.wlan_config_present;
                  nxt.cell_path_down = 1'b0;
                  sv  = 1'b1;
                  chg = 1'b1;
                  if (is_wlan && !cfg.wlan_config_present) begin
                     nxt.reconnecting   = 1'b0;
                     nxt.current_op     = lrds_pkg::OP_NONE;
                     nxt.awaited_effect = lrds_pkg::EF_NONE;
                     st = lrds_pkg::ST_FAILED;
                  end else begin
                     if (is_cell || (is_dual && !cfg.wlan_config_present)) begin
                        nxt.awaited_effect = lrds_pkg::EF_CELL_OFF;
                     end else begin
                        nxt.awaited_effect = lrds_pkg::EF_APPLY_CFG;
                     end
                     eff = nxt.awaited_effect;
                  end
               end
            end

            lrds_pkg::FN_EFFECT_OK, lrds_pkg::FN_EFFECT_BAD: begin
               if (done == lrds_pkg::EF_NONE) begin
                  rc = lrds_pkg::RC_BAD_STATE;
               end else if (cur.current_op == lrds_pkg::OP_RECONNECT) begin
                  if (fail) begin
                     nxt.op_failed = 1'b1;
                     if (done == lrds_pkg::EF_APPLY_CFG) begin
                        nxt.wlan_path_down = 1'b1;
                     end else if (done == lrds_pkg::EF_CELL_OFF ||
                                  done == lrds_pkg::EF_CELL_ON) begin
                        nxt.cell_path_down = 1'b1;
                     end
                  end
                  nxt.op_step = step_inc;
                  if (done == lrds_pkg::EF_APPLY_CFG && !fail) begin
                     nxt.awaited_effect = lrds_pkg::EF_CONNECT_WLAN;
                  end else if ((done == lrds_pkg::EF_APPLY_CFG ||
                                done == lrds_pkg::EF_CONNECT_WLAN) && is_dual) begin
                     nxt.awaited_effect = lrds_pkg::EF_CELL_OFF;
                  end else if (done == lrds_pkg::EF_CELL_OFF && !fail) begin
                     nxt.awaited_effect = lrds_pkg::EF_CELL_ON;
                  end else begin
                     nxt.awaited_effect = lrds_pkg::EF_NONE;
                  end
                  no_path = (is_wlan && nxt.wlan_path_down) ||
                            (is_cell && nxt.cell_path_down) ||
                            (is_dual && nxt.wlan_path_down && nxt.cell_path_down);
                  if (no_path) begin
                     nxt.reconnecting   = 1'b0;
                     nxt.current_op     = lrds_pkg::OP_NONE;
                     nxt.awaited_effect = lrds_pkg::EF_NONE;
                     sv  = 1'b1;
                     st  = lrds_pkg::ST_FAILED;
                     chg = 1'b1;
                  end else begin
                     eff = nxt.awaited_effect;
                  end
               end else if (cur.current_op != lrds_pkg::OP_DISCONNECT) begin
                  rc = lrds_pkg::RC_BAD_STATE;
               end else begin
                  if (fail) begin
                     nxt.op_failed = 1'b1;
                  end
                  nxt.op_step = step_inc;
                  if (is_dual && step_inc == 3'd1) begin
                     nxt.awaited_effect = lrds_pkg::EF_DISC_WLAN;
                     eff = lrds_pkg::EF_DISC_WLAN;
                  end else if (is_dual && step_inc == 3'd2) begin
                     nxt.awaited_effect = lrds_pkg::EF_CELL_OFF;
                     eff = lrds_pkg::EF_CELL_OFF;
                  end else begin
                     nxt.awaited_effect = lrds_pkg::EF_NONE;
                     nxt.current_op     = lrds_pkg::OP_NONE;
                     nxt.disconnecting  = 1'b0;
                     sv  = 1'b1;
                     st  = nxt.op_failed ? lrds_pkg::ST_FAILED : lrds_pkg::ST_COMPLETED;
                     chg = 1'b1;
                  end
               end
            end

            lrds_pkg::FN_READY: begin
               nxt.ready_state  = req.ready_flag;
               nxt.active_iface = req.ready_flag ? req.ready_iface : 2'd0;
               chg = 1'b1;
               if (req.ready_flag && cur.reconnecting &&
                   cur.awaited_effect == lrds_pkg::EF_NONE) begin
                  nxt.reconnecting = 1'b0;
                  nxt.current_op   = lrds_pkg::OP_NONE;
                  sv = 1'b1;
                  st = lrds_pkg::ST_COMPLETED;
               end
            end

            lrds_pkg::FN_TERMINAL: begin
               if (!cur.reconnecting || cur.current_op != lrds_pkg::OP_RECONNECT) begin
                  rc = lrds_pkg::RC_BAD_STATE;
               end else begin
                  nxt.reconnecting   = 1'b0;
                  nxt.current_op     = lrds_pkg::OP_NONE;
                  nxt.awaited_effect = lrds_pkg::EF_NONE;
                  sv  = 1'b1;
                  st  = lrds_pkg::ST_FAILED;
                  chg = 1'b1;
               end
            end

            lrds_pkg::FN_DISCONNECT: begin
               if (cur.disconnecting) begin
                  sv = 1'b1;
                  st = lrds_pkg::ST_BUSY;
               end else if (cur.offline_flag) begin
                  sv = 1'b1;
                  st = lrds_pkg::ST_NO_ACTION;
               end else begin
                  nxt.offline_flag  = 1'b1;
                  nxt.ready_state   = 1'b0;
                  nxt.active_iface  = 2'd0;
                  nxt.disconnecting = 1'b1;
                  nxt.current_op    = lrds_pkg::OP_DISCONNECT;
                  nxt.op_step       = 3'd0;
                  nxt.op_failed     = 1'b0;
                  if (is_wlan) begin
                     nxt.awaited_effect = lrds_pkg::EF_DISC_WLAN;
                  end else if (is_cell) begin
                     nxt.awaited_effect = lrds_pkg::EF_CELL_OFF;
                  end else begin
                     nxt.awaited_effect = lrds_pkg::EF_REPORT_DOWN;
                  end
                  eff = nxt.awaited_effect;
                  sv  = 1'b1;
                  chg = 1'b1;
               end
            end

            default: rc = lrds_pkg::RC_UNSUPPORTED;
         endcase
      end

      rsp.result_code  = rc;
      rsp.next_effect  = eff;
      rsp.status_valid = sv;
      rsp.op_status    = sv ? st : lrds_pkg::ST_ACCEPTED;
      rsp.snap_changed = chg;
      rsp.snap_ready   = nxt.ready_state;
      rsp.snap_iface   = nxt.active_iface;
      rsp.snap_offline = nxt.offline_flag;
   end

endmodule

// File: hw/rtl/link_reconnect_disconnect_sequencer.sv
// Top level of the link reconnect/disconnect sequencer.
// Depends on lrds_pkg, lrds_csr and lrds_step.
//
// Usage:
//   req channel (req_valid/req_stall/req_item) carries events: requests,
//   effect feedback, stable-ready and terminal failure. rsp channel
//   (rsp_valid/rsp_stall/rsp_item) returns exactly one result item per event.
//   The APB-style port holds link_mode, manager_started and
//   wlan_config_present at byte addresses 0, 4 and 8; write them while idle.
// Timing:
//   An event is registered on acceptance, decided by the combinational step
//   logic and lands in the result register when that register is empty or
//   being drained. One event per clock is sustained while rsp_stall is low;
//   the sequencer state register updates in the same cycle as the result
//   register, so back-to-back events see each other's effect.
// Reset: synchronous; clears the configuration, the sequencer state and both
//   valid flags. When rsp_stall is high the result holds, the input register
//   fills, and req_stall rises until the result is taken.
module link_reconnect_disconnect_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lrds_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lrds_pkg::rsp_item_type              rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lrds_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lrds_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lrds_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   lrds_pkg::cfg_type       cfg;
   lrds_pkg::seq_state_type state_ff, state_in;
   lrds_pkg::req_item_type  in_item_ff;
   lrds_pkg::rsp_item_type  out_item_ff, step_rsp;
   logic                    in_valid_ff, in_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    advance;
   logic                    req_take;

   lrds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lrds_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (in_item_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // held item moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// File: hw/rtl/lrds_checker.sv
// Port-level checks for the link reconnect/disconnect sequencer, bound to the top.
// Depends on lrds_pkg for codes and the result item type.
module lrds_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input lrds_pkg::rsp_item_type rsp_item
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // error results carry no effect, no status and no snapshot change
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_code != lrds_pkg::RC_OK |->
         rsp_item.next_effect == lrds_pkg::EF_NONE && !rsp_item.status_valid &&
         !rsp_item.snap_changed)
      else $error("error result with effect, status or snapshot change");

   // an issued effect comes either alone or with an accepted status
   a_effect_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.next_effect != lrds_pkg::EF_NONE |->
         !rsp_item.status_valid || rsp_item.op_status == lrds_pkg::ST_ACCEPTED)
      else $error("effect issued with a final status");

   // op_status is zero whenever no report is flagged
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.status_valid |->
         rsp_item.op_status == lrds_pkg::ST_ACCEPTED)
      else $error("op_status set without status_valid");

endmodule

bind link_reconnect_disconnect_sequencer lrds_checker u_lrds_checker (.*);

// File: verif/tb_link_reconnect_disconnect_sequencer.sv
// Testbench for link_reconnect_disconnect_sequencer: drives events, writes the APB registers,
// and checks every result against an in-bench model of the sequencer.
// Depends on lrds_pkg and the sequencer RTL only.
module tb_link_reconnect_disconnect_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_CYCLES = 90;

   class link_outcome_board;
      logic [1:0] link_mode;
      logic       started;
      logic       wlan_cfg;

      logic       offline;
      logic       ready;
      logic [1:0] iface;
      logic       reconnecting;
      logic       disconnecting;
      lrds_pkg::op_type cur_op;
      logic [2:0] op_step;
      logic       op_failed;
      logic       wlan_down;
      logic       cell_down;
      logic [2:0] awaited;

      lrds_pkg::rsp_item_type outcomes_due[$];
      int errors;

      function new();
         link_mode = lrds_pkg::MODE_WLAN;
         started = 1'b0;
         wlan_cfg = 1'b0;
         offline = 1'b0;
         ready = 1'b0;
         iface = 2'd0;
         reconnecting = 1'b0;
         disconnecting = 1'b0;
         cur_op = lrds_pkg::OP_NONE;
         op_step = 3'd0;
         op_failed = 1'b0;
         wlan_down = 1'b0;
         cell_down = 1'b0;
         awaited = lrds_pkg::EF_NONE;
         errors = 0;
      endfunction

      function void set_config(logic [1:0] idx, logic [31:0] v);
         case (idx)
            lrds_pkg::REG_LINK_MODE: link_mode = v[1:0];
            lrds_pkg::REG_STARTED:   started = v[0];
            lrds_pkg::REG_WLAN_CFG:  wlan_cfg = v[0];
            default: ;
         endcase
      endfunction

      function void end_reconnect();
         reconnecting = 1'b0;
         cur_op = lrds_pkg::OP_NONE;
         awaited = lrds_pkg::EF_NONE;
      endfunction

      function lrds_pkg::rsp_item_type next_outcome(lrds_pkg::req_item_type ev);
         lrds_pkg::rsp_item_type r;
         logic failed;
         logic no_path;
         logic [2:0] done;
         r = '0;
         if (link_mode == lrds_pkg::MODE_BAD) begin
            r.result_code = lrds_pkg::RC_BAD_MODE;
         end else if (!started ||
                      (ev.func == lrds_pkg::FN_RECONNECT && disconnecting) ||
                      (ev.func == lrds_pkg::FN_DISCONNECT && reconnecting)) begin
            r.result_code = lrds_pkg::RC_BAD_STATE;
         end else begin
            case (ev.func)
               lrds_pkg::FN_RECONNECT: begin
                  if (reconnecting) begin
                     r.status_valid = 1'b1;
                     r.op_status = lrds_pkg::ST_BUSY;
                  end else begin
                     offline = 1'b0;
                     ready = 1'b0;
                     iface = 2'd0;
                     reconnecting = 1'b1;
                     disconnecting = 1'b0;
                     cur_op = lrds_pkg::OP_RECONNECT;
                     op_step = 3'd0;
                     op_failed = 1'b0;
                     wlan_down = (link_mode == lrds_pkg::MODE_DUAL) && !wlan_cfg;
                     cell_down = 1'b0;
                     r.status_valid = 1'b1;
                     r.snap_changed = 1'b1;
                     if (link_mode == lrds_pkg::MODE_WLAN && !wlan_cfg) begin
                        end_reconnect();
                        r.op_status = lrds_pkg::ST_FAILED;
                     end else begin
                        if (link_mode == lrds_pkg::MODE_CELL ||
                            (link_mode == lrds_pkg::MODE_DUAL && !wlan_cfg))
                           awaited = lrds_pkg::EF_CELL_OFF;
                        else
                           awaited = lrds_pkg::EF_APPLY_CFG;
                        r.next_effect = awaited;
                        r.op_status = lrds_pkg::ST_ACCEPTED;
                     end
                  end
               end
               lrds_pkg::FN_EFFECT_OK, lrds_pkg::FN_EFFECT_BAD: begin
                  failed = (ev.func == lrds_pkg::FN_EFFECT_BAD);
                  done = awaited;
                  if (done == lrds_pkg::EF_NONE) begin
                     r.result_code = lrds_pkg::RC_BAD_STATE;
                  end else if (cur_op == lrds_pkg::OP_RECONNECT) begin
                     if (failed) begin
                        op_failed = 1'b1;
                        if (done == lrds_pkg::EF_APPLY_CFG)
                           wlan_down = 1'b1;
                        else if (done == lrds_pkg::EF_CELL_OFF ||
                                 done == lrds_pkg::EF_CELL_ON)
                           cell_down = 1'b1;
                     end
                     op_step = op_step + 3'd1;
                     if (done == lrds_pkg::EF_APPLY_CFG && !failed)
                        awaited = lrds_pkg::EF_CONNECT_WLAN;
                     else if ((done == lrds_pkg::EF_APPLY_CFG ||
                               done == lrds_pkg::EF_CONNECT_WLAN) &&
                              link_mode == lrds_pkg::MODE_DUAL)
                        awaited = lrds_pkg::EF_CELL_OFF;
                     else if (done == lrds_pkg::EF_CELL_OFF && !failed)
                        awaited = lrds_pkg::EF_CELL_ON;
                     else
                        awaited = lrds_pkg::EF_NONE;
                     no_path = (link_mode == lrds_pkg::MODE_WLAN && wlan_down) ||
                               (link_mode == lrds_pkg::MODE_CELL && cell_down) ||
                               (link_mode == lrds_pkg::MODE_DUAL && wlan_down &&
                                cell_down);
                     if (no_path) begin
                        end_reconnect();
                        r.status_valid = 1'b1;
                        r.op_status = lrds_pkg::ST_FAILED;
                        r.snap_changed = 1'b1;
                     end else begin
                        r.next_effect = awaited;
                     end
                  end else if (cur_op != lrds_pkg::OP_DISCONNECT) begin
                     r.result_code = lrds_pkg::RC_BAD_STATE;
                  end else begin
                     if (failed)
                        op_failed = 1'b1;
                     op_step = op_step + 3'd1;
                     if (link_mode == lrds_pkg::MODE_DUAL && op_step == 3'd1) begin
                        awaited = lrds_pkg::EF_DISC_WLAN;
                     end else if (link_mode == lrds_pkg::MODE_DUAL && op_step == 3'd2) begin
                        awaited = lrds_pkg::EF_CELL_OFF;
                     end else begin
                        awaited = lrds_pkg::EF_NONE;
                        cur_op = lrds_pkg::OP_NONE;
                        disconnecting = 1'b0;
                        r.status_valid = 1'b1;
                        r.op_status = op_failed ? lrds_pkg::ST_FAILED :
                                                  lrds_pkg::ST_COMPLETED;
                        r.snap_changed = 1'b1;
                     end
                     r.next_effect = awaited;
                  end
               end
               lrds_pkg::FN_READY: begin
                  ready = ev.ready_flag;
                  iface = ev.ready_flag ? ev.ready_iface : 2'd0;
                  r.snap_changed = 1'b1;
                  if (ev.ready_flag && reconnecting && awaited == lrds_pkg::EF_NONE) begin
                     reconnecting = 1'b0;
                     cur_op = lrds_pkg::OP_NONE;
                     r.status_valid = 1'b1;
                     r.op_status = lrds_pkg::ST_COMPLETED;
                  end
               end
               lrds_pkg::FN_TERMINAL: begin
                  if (!reconnecting || cur_op != lrds_pkg::OP_RECONNECT) begin
                     r.result_code = lrds_pkg::RC_BAD_STATE;
                  end else begin
                     end_reconnect();
                     r.status_valid = 1'b1;
                     r.op_status = lrds_pkg::ST_FAILED;
                     r.snap_changed = 1'b1;
                  end
               end
               lrds_pkg::FN_DISCONNECT: begin
                  r.status_valid = 1'b1;
                  if (disconnecting) begin
                     r.op_status = lrds_pkg::ST_BUSY;
                  end else if (offline) begin
                     r.op_status = lrds_pkg::ST_NO_ACTION;
                  end else begin
                     offline = 1'b1;
                     ready = 1'b0;
                     iface = 2'd0;
                     disconnecting = 1'b1;
                     cur_op = lrds_pkg::OP_DISCONNECT;
                     op_step = 3'd0;
                     op_failed = 1'b0;
                     if (link_mode == lrds_pkg::MODE_WLAN)
                        awaited = lrds_pkg::EF_DISC_WLAN;
                     else if (link_mode == lrds_pkg::MODE_CELL)
                        awaited = lrds_pkg::EF_CELL_OFF;
                     else
                        awaited = lrds_pkg::EF_REPORT_DOWN;
                     r.next_effect = awaited;
                     r.op_status = lrds_pkg::ST_ACCEPTED;
                     r.snap_changed = 1'b1;
                  end
               end
               default: r.result_code = lrds_pkg::RC_UNSUPPORTED;
            endcase
         end
         r.snap_ready = ready;
         r.snap_iface = iface;
         r.snap_offline = offline;
         return r;
      endfunction

      function void note_request(lrds_pkg::req_item_type ev);
         outcomes_due.push_back(next_outcome(ev));
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(lrds_pkg::rsp_item_type got);
         lrds_pkg::rsp_item_type want;
         if (outcomes_due.size() == 0) begin
            $error("result with no item outstanding: %h", got);
            errors++;
            return;
         end
         want = outcomes_due.pop_front();
         compare("result_code", want.result_code, got.result_code);
         compare("next_effect", want.next_effect, got.next_effect);
         compare("status_valid", want.status_valid, got.status_valid);
         compare("op_status", want.op_status, got.op_status);
         compare("snap_changed", want.snap_changed, got.snap_changed);
         compare("snap_ready", want.snap_ready, got.snap_ready);
         compare("snap_iface", want.snap_iface, got.snap_iface);
         compare("snap_offline", want.snap_offline, got.snap_offline);
      endfunction

      function int pending();
         return outcomes_due.size();
      endfunction

      function void flag_leftovers();
         if (outcomes_due.size() != 0) begin
            $error("%0d results never arrived", outcomes_due.size());
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   lrds_pkg::req_item_type req_item;
   logic rsp_valid;
   logic rsp_stall;
   lrds_pkg::rsp_item_type rsp_item;
   logic psel;
   logic penable;
   logic pwrite;
   logic [lrds_pkg::CSR_ADDR_W-1:0] paddr;
   logic [lrds_pkg::CSR_DATA_W-1:0] pwdata;
   logic [lrds_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   link_outcome_board board = new();
   int items_sent = 0;
   int cycle_count = 0;
   bit sender_gaps_on = 1'b1;
   bit hold_request = 1'b0;

   link_reconnect_disconnect_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic lrds_pkg::req_item_type event_of(logic [2:0] f, logic fl,
                                                       logic [1:0] ifc);
      lrds_pkg::req_item_type ev;
      ev.func = f;
      ev.ready_flag = fl;
      ev.ready_iface = ifc;
      return ev;
   endfunction

   function automatic lrds_pkg::req_item_type random_event(logic [2:0] f);
      return event_of(f, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
   endfunction

   task automatic send_event(lrds_pkg::req_item_type ev);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_item = ev;
      do @(posedge clock); while (req_stall);
      board.note_request(ev);
      items_sent++;
   endtask

   task automatic quiet_req();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      board.set_config(idx, val);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // registers change only with nothing in flight
   task automatic apply_config(logic [1:0] m, logic s, logic w);
      quiet_req();
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      write_csr(lrds_pkg::REG_LINK_MODE, 32'(m));
      write_csr(lrds_pkg::REG_STARTED, 32'(s));
      write_csr(lrds_pkg::REG_WLAN_CFG, 32'(w));
   endtask

   task automatic feedback_burst(int n);
      repeat (n)
         send_event(random_event(($urandom_range(0, 3) == 0) ?
                                 lrds_pkg::FN_EFFECT_BAD : lrds_pkg::FN_EFFECT_OK));
   endtask

   // mostly well-formed operations with random outcomes, some noise
   task automatic run_episode();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         send_event(random_event(lrds_pkg::FN_RECONNECT));
         feedback_burst($urandom_range(1, 5));
         if ($urandom_range(0, 9) == 0)
            send_event(random_event(lrds_pkg::FN_TERMINAL));
         else
            send_event(event_of(lrds_pkg::FN_READY, $urandom_range(0, 4) != 0,
                                2'($urandom_range(0, 3))));
      end else if (kind < 75) begin
         send_event(random_event(lrds_pkg::FN_DISCONNECT));
         feedback_burst($urandom_range(1, 4));
      end else begin
         repeat ($urandom_range(1, 3))
            send_event(random_event(3'($urandom_range(0, 7))));
      end
   endtask

   initial begin : drain
      int wait_left;
      int taken;
      bit idle_on;
      wait_left = 0;
      taken = 0;
      idle_on = 1'b1;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_result(rsp_item);
            taken++;
            if (taken % 64 == 0)
               idle_on = $urandom_range(0, 2) != 0;
            wait_left = idle_on ? $urandom_range(0, 11) : 0;
         end
         @(negedge clock);
         if (hold_request) begin
            wait_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         rsp_stall = (wait_left > 0);
         if (wait_left > 0)
            wait_left--;
      end
   end

   initial begin : stimulus
      int phase;
      int phase_end;
      int target;
      logic [1:0] m;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // manager not started after reset
      send_event(event_of(lrds_pkg::FN_RECONNECT, 1'b0, 2'd0));
      send_event(event_of(3'd6, 1'b1, 2'd3));

      // invalid mode wins over everything
      apply_config(lrds_pkg::MODE_BAD, 1'b1, 1'b1);
      send_event(event_of(lrds_pkg::FN_RECONNECT, 1'b1, 2'd1));
      send_event(event_of(3'd7, 1'b0, 2'd2));

      // wireless only without a stored configuration
      apply_config(lrds_pkg::MODE_WLAN, 1'b1, 1'b0);
      send_event(event_of(lrds_pkg::FN_RECONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_DISCONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_RECONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_OK, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_DISCONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_OK, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_TERMINAL, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_READY, 1'b1, 2'd3));

      // dual automatic: full reconnect and disconnect sequences
      apply_config(lrds_pkg::MODE_DUAL, 1'b1, 1'b1);
      send_event(event_of(lrds_pkg::FN_RECONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_DISCONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_RECONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_BAD, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_OK, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_OK, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_READY, 1'b1, 2'd2));
      send_event(event_of(lrds_pkg::FN_RECONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_TERMINAL, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_DISCONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_DISCONNECT, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_BAD, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_OK, 1'b0, 2'd0));
      send_event(event_of(lrds_pkg::FN_EFFECT_OK, 1'b0, 2'd0));

      target = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < target) begin
         if (phase == 2) begin
            apply_config(lrds_pkg::MODE_DUAL, 1'b1, 1'b1);
            // back-to-back items against a long receiver hold-off
            sender_gaps_on = 1'b0;
            hold_request = 1'b1;
         end else begin
            m = ($urandom_range(0, 11) == 0) ? lrds_pkg::MODE_BAD :
                                               2'($urandom_range(0, 2));
            apply_config(m, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
            sender_gaps_on = $urandom_range(0, 2) != 0;
         end
         phase_end = items_sent + 120;
         while (items_sent < phase_end && items_sent < target)
            run_episode();
         phase++;
      end

      quiet_req();
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      board.flag_leftovers();
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
